@@ design/upng_pkg.sv @@
// shared types, constants and checksum helpers for the png stream encoder
// no dependencies
package upng_pkg;

   localparam int MAX_SIDE = 128;
   localparam int SIDE_W   = 8;
   localparam int RAW_W    = 17;

   localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
   localparam logic [31:0] ALL_ONES  = 32'hFFFFFFFF;
   localparam logic [16:0] ADLER_MOD = 17'd65521;
   localparam logic [15:0] BLOCK_MAX = 16'hFFFF;

   // input action codes
   localparam logic [1:0] ACT_START  = 2'd0;
   localparam logic [1:0] ACT_PIXEL  = 2'd1;
   localparam logic [1:0] ACT_FINISH = 2'd2;

   // work kinds passed from front to back
   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   // configuration register indexes
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef struct packed {
      logic [1:0]        kind;
      logic              row_start;
      logic [31:0]       pixel;
      logic [SIDE_W-1:0] width;
      logic [SIDE_W-1:0] height;
      logic [RAW_W-1:0]  raw;
   } work_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function automatic logic [15:0] adler_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= ADLER_MOD) begin
         s = s - ADLER_MOD;
      end
      return s[15:0];
   endfunction

endpackage

@@ design/uncompressed_png_stream_encoder.sv @@
// top level of the png stream encoder (rgba8, zlib stored blocks)
// depends on upng_pkg, upng_front, upng_queue, upng_back
//
//   channel   dir  payload                                  beat taken when
//   req_*     in   tdata pixel_argb, tuser action           tvalid & tready
//   rsp_*     out  tdata out_byte, tlast run_last,          tvalid & tready
//                  tuser order_error
//   csr_*     in   image_width @0x0, image_height @0x4      psel & penable & pwrite
//
// one output byte per cycle, unless rsp_tready stalls it, from the back sequencer's
// output register; bytes per item: start 43, pixel 4 or 5 (9 or 10
// where a stored block header falls in it), finish 20, out-of-order item 1
// the front classifies and queues items one per cycle, unless the queue is full,
// into a two-entry queue; input is taken while the back still streams earlier bytes
// synchronous active-high reset; no clearing pass, the block is ready right after
// output stalls hold the byte register and back up through the queue to req_tready
module uncompressed_png_stream_encoder (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] pixel_argb
   input  logic [1:0]  req_tuser,   // [1:0] action
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser,   // [0] order_error
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import upng_pkg::*;

   logic [SIDE_W-1:0] width_ff, height_ff;
   logic              csr_wr;
   logic              q_full, q_push, q_valid, q_pop;
   work_type          q_entry, q_head;

   // register file, byte offset ignored
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIDE_W'(1);
         height_ff <= SIDE_W'(1);
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_WIDTH) begin
            width_ff <= csr_pwdata[SIDE_W-1:0];
         end else begin
            height_ff <= csr_pwdata[SIDE_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_HEIGHT) begin
         csr_prdata = {24'd0, height_ff};
      end else begin
         csr_prdata = {24'd0, width_ff};
      end
   end

   // front: classify and track rows/columns
   upng_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .req_pixel  (req_tdata),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   // decoupling queue
   upng_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   // back: byte sequencer and checksums
   upng_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ design/upng_front.sv @@
// front part: classifies input beats, tracks image position, fills the work queue
// depends on upng_pkg
module upng_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [1:0]             req_action,
   input  logic [31:0]            req_pixel,
   input  logic [upng_pkg::SIDE_W-1:0] cfg_width,
   input  logic [upng_pkg::SIDE_W-1:0] cfg_height,
   input  logic                   q_full,
   output logic                   q_push,
   output upng_pkg::work_type     q_entry
);
   import upng_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_TAKE = 2'd1;
   localparam logic [1:0] PH_DONE = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic [SIDE_W-1:0] col_ff, col_in;
   logic [SIDE_W-1:0] row_ff, row_in;
   logic [SIDE_W-1:0] latw_ff, latw_in;
   logic [SIDE_W-1:0] lath_ff, lath_in;
   logic [SIDE_W-1:0] cw, ch;
   logic [SIDE_W:0]   col_next, row_next;

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
      if (v == '0) begin
         return SIDE_W'(1);
      end
      if ({1'b0, v} > (SIDE_W+1)'(MAX_SIDE)) begin
         return SIDE_W'(MAX_SIDE);
      end
      return v;
   endfunction

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;
   assign cw         = clamp_side(cfg_width);
   assign ch         = clamp_side(cfg_height);
   assign col_next   = {1'b0, col_ff} + 1'b1;
   assign row_next   = {1'b0, row_ff} + 1'b1;

   always_comb begin
      q_entry           = '0;
      q_entry.pixel     = req_pixel;
      q_entry.row_start = (col_ff == '0);
      q_entry.width     = cw;
      q_entry.height    = ch;
      // raw payload bytes: rows times (filter byte plus four per pixel)
      q_entry.raw       = RAW_W'(ch) * (RAW_W'({cw, 2'b00}) + RAW_W'(1));
      phase_in          = phase_ff;
      col_in            = col_ff;
      row_in            = row_ff;
      latw_in           = latw_ff;
      lath_in           = lath_ff;
      if (req_action == ACT_START && phase_ff == PH_IDLE) begin
         q_entry.kind = KIND_START;
         phase_in     = PH_TAKE;
         col_in       = '0;
         row_in       = '0;
         latw_in      = cw;
         lath_in      = ch;
      end else if (req_action == ACT_PIXEL && phase_ff == PH_TAKE) begin
         q_entry.kind = KIND_PIXEL;
         col_in       = col_next[SIDE_W-1:0];
         if (col_next >= {1'b0, latw_ff}) begin
            col_in = '0;
            row_in = row_next[SIDE_W-1:0];
            if (row_next >= {1'b0, lath_ff}) begin
               phase_in = PH_DONE;
            end
         end
      end else if (req_action == ACT_FINISH && phase_ff == PH_DONE) begin
         q_entry.kind = KIND_FINISH;
         phase_in     = PH_IDLE;
         col_in       = '0;
         row_in       = '0;
      end else begin
         q_entry.kind = KIND_ERROR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         latw_ff  <= '0;
         lath_ff  <= '0;
      end else if (q_push) begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         latw_ff  <= latw_in;
         lath_ff  <= lath_in;
      end
   end

endmodule

@@ design/upng_queue.sv @@
// two-entry work queue between the front and back parts
// depends on upng_pkg
module upng_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  upng_pkg::work_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output upng_pkg::work_type head
);
   import upng_pkg::*;

   work_type   mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign head  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

@@ design/upng_back.sv @@
// back part: byte sequencer with crc-32, adler-32 and stored block framing
// depends on upng_pkg
module upng_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  upng_pkg::work_type q_head,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast,
   output logic               rsp_tuser
);
   import upng_pkg::*;

   logic              adv;
   logic [5:0]        step_ff, step_in;
   logic              hact_ff, hact_in;
   logic [2:0]        hpos_ff, hpos_in;
   logic [15:0]       len_ff, len_in;
   logic              fin_ff, fin_in;
   logic [31:0]       crc_ff, crc_in;
   logic [15:0]       alo_ff, alo_in, ahi_ff, ahi_in;
   logic [15:0]       blk_ff, blk_in;
   logic [RAW_W-1:0]  rawl_ff, rawl_in;
   logic              ov_ff;
   logic [7:0]        ob_ff, byte_c;
   logic              ol_ff, oe_ff, last_c, err_c, chk_c;
   logic [31:0]       seed_c, crcx, adl, idat_len;
   logic [2:0]        ridx, hp;
   logic [15:0]       lenv, nlen, alo_n;
   logic              finv;
   logic [1:0]        blocks;

   assign adv        = q_valid && (!ov_ff || rsp_tready);
   assign q_pop      = adv && last_c;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = ob_ff;
   assign rsp_tlast  = ol_ff;
   assign rsp_tuser  = oe_ff;
   assign crcx       = crc_ff ^ ALL_ONES;
   assign adl        = {ahi_ff, alo_ff};
   assign blocks     = (q_head.raw <= RAW_W'(BLOCK_MAX)) ? 2'd1 :
                       (q_head.raw <= RAW_W'(2 * 65535)) ? 2'd2 : 2'd3;
   assign idat_len   = 32'(q_head.raw) + 32'd6 + 32'(blocks) * 32'd5;

   always_comb begin
      step_in = step_ff;
      hact_in = hact_ff;
      hpos_in = hpos_ff;
      len_in  = len_ff;
      fin_in  = fin_ff;
      crc_in  = crc_ff;
      alo_in  = alo_ff;
      ahi_in  = ahi_ff;
      blk_in  = blk_ff;
      rawl_in = rawl_ff;
      byte_c  = 8'd0;
      last_c  = 1'b0;
      err_c   = 1'b0;
      chk_c   = 1'b0;
      seed_c  = crc_ff;
      ridx    = step_ff[2:0] + {2'b0, !q_head.row_start};
      lenv    = (rawl_ff > RAW_W'(BLOCK_MAX)) ? BLOCK_MAX : rawl_ff[15:0];
      finv    = (RAW_W'(lenv) == rawl_ff);
      hp      = 3'd0;
      nlen    = 16'd0;
      alo_n   = alo_ff;
      case (q_head.kind)
         KIND_START: begin
            case (step_ff)
               6'd0:  byte_c = 8'h89;
               6'd1:  byte_c = 8'h50;
               6'd2:  byte_c = 8'h4E;
               6'd3:  byte_c = 8'h47;
               6'd4:  byte_c = 8'h0D;
               6'd5:  byte_c = 8'h0A;
               6'd6:  byte_c = 8'h1A;
               6'd7:  byte_c = 8'h0A;
               6'd11: byte_c = 8'h0D;
               6'd12: byte_c = 8'h49;
               6'd13: byte_c = 8'h48;
               6'd14: byte_c = 8'h44;
               6'd15: byte_c = 8'h52;
               6'd19: byte_c = q_head.width;
               6'd23: byte_c = q_head.height;
               6'd24: byte_c = 8'h08;
               6'd25: byte_c = 8'h06;
               6'd29: byte_c = crcx[31:24];
               6'd30: byte_c = crcx[23:16];
               6'd31: byte_c = crcx[15:8];
               6'd32: byte_c = crcx[7:0];
               6'd33: byte_c = idat_len[31:24];
               6'd34: byte_c = idat_len[23:16];
               6'd35: byte_c = idat_len[15:8];
               6'd36: byte_c = idat_len[7:0];
               6'd37: byte_c = 8'h49;
               6'd38: byte_c = 8'h44;
               6'd39: byte_c = 8'h41;
               6'd40: byte_c = 8'h54;
               6'd41: byte_c = 8'h78;
               6'd42: byte_c = 8'h01;
               default: byte_c = 8'h00;
            endcase
            chk_c = (step_ff >= 6'd12 && step_ff <= 6'd28) || (step_ff >= 6'd37);
            if (step_ff == 6'd12 || step_ff == 6'd37) begin
               seed_c = ALL_ONES;
            end
            last_c  = (step_ff == 6'd42);
            step_in = step_ff + 6'd1;
            if (last_c) begin
               alo_in  = 16'd1;
               ahi_in  = 16'd0;
               blk_in  = 16'd0;
               rawl_in = q_head.raw;
               hact_in = 1'b0;
            end
         end
         KIND_PIXEL: begin
            chk_c = 1'b1;
            if (hact_ff || (blk_ff == 16'd0 && rawl_ff != '0)) begin
               // stored block header: final flag, len, nlen
               hp = hact_ff ? hpos_ff : 3'd0;
               if (!hact_ff) begin
                  len_in = lenv;
                  fin_in = finv;
               end
               nlen = ~len_in;
               case (hp)
                  3'd0:    byte_c = {7'd0, fin_in};
                  3'd1:    byte_c = len_in[7:0];
                  3'd2:    byte_c = len_in[15:8];
                  3'd3:    byte_c = nlen[7:0];
                  default: byte_c = nlen[15:8];
               endcase
               if (hp == 3'd4) begin
                  hact_in = 1'b0;
                  blk_in  = len_in;
               end else begin
                  hact_in = 1'b1;
                  hpos_in = hp + 3'd1;
               end
            end else begin
               case (ridx)
                  3'd1:    byte_c = q_head.pixel[23:16];
                  3'd2:    byte_c = q_head.pixel[15:8];
                  3'd3:    byte_c = q_head.pixel[7:0];
                  3'd4:    byte_c = q_head.pixel[31:24];
                  default: byte_c = 8'h00;
               endcase
               alo_n  = adler_add(alo_ff, {8'd0, byte_c});
               alo_in = alo_n;
               ahi_in = adler_add(ahi_ff, alo_n);
               if (blk_ff != 16'd0) begin
                  blk_in = blk_ff - 16'd1;
               end
               if (rawl_ff != '0) begin
                  rawl_in = rawl_ff - 1'b1;
               end
               step_in = step_ff + 6'd1;
               last_c  = (ridx == 3'd4);
            end
         end
         KIND_FINISH: begin
            case (step_ff)
               6'd0:  byte_c = adl[31:24];
               6'd1:  byte_c = adl[23:16];
               6'd2:  byte_c = adl[15:8];
               6'd3:  byte_c = adl[7:0];
               6'd4:  byte_c = crcx[31:24];
               6'd5:  byte_c = crcx[23:16];
               6'd6:  byte_c = crcx[15:8];
               6'd7:  byte_c = crcx[7:0];
               6'd12: byte_c = 8'h49;
               6'd13: byte_c = 8'h45;
               6'd14: byte_c = 8'h4E;
               6'd15: byte_c = 8'h44;
               6'd16: byte_c = 8'hAE;
               6'd17: byte_c = 8'h42;
               6'd18: byte_c = 8'h60;
               6'd19: byte_c = 8'h82;
               default: byte_c = 8'h00;
            endcase
            chk_c   = (step_ff <= 6'd3);
            last_c  = (step_ff == 6'd19);
            step_in = step_ff + 6'd1;
         end
         default: begin
            last_c = 1'b1;
            err_c  = 1'b1;
         end
      endcase
      if (chk_c) begin
         crc_in = crc_byte(seed_c, byte_c);
      end
      if (last_c) begin
         step_in = 6'd0;
         if (q_head.kind == KIND_FINISH) begin
            crc_in  = ALL_ONES;
            alo_in  = 16'd1;
            ahi_in  = 16'd0;
            blk_in  = 16'd0;
            rawl_in = '0;
            hact_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 6'd0;
         hact_ff <= 1'b0;
         hpos_ff <= 3'd0;
         crc_ff  <= ALL_ONES;
         alo_ff  <= 16'd1;
         ahi_ff  <= 16'd0;
         blk_ff  <= 16'd0;
         rawl_ff <= '0;
         ov_ff   <= 1'b0;
      end else if (adv) begin
         step_ff <= step_in;
         hact_ff <= hact_in;
         hpos_ff <= hpos_in;
         crc_ff  <= crc_in;
         alo_ff  <= alo_in;
         ahi_ff  <= ahi_in;
         blk_ff  <= blk_in;
         rawl_ff <= rawl_in;
         ov_ff   <= 1'b1;
      end else if (rsp_tready) begin
         ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ob_ff  <= byte_c;
         ol_ff  <= last_c;
         oe_ff  <= err_c;
         len_ff <= len_in;
         fin_ff <= fin_in;
      end
   end

   a_hdr_only_when_block_empty: assert property (@(posedge clock) disable iff (reset)
      hact_ff |-> (blk_ff == 16'd0))
      else $error("block header active with bytes left in block");

   a_block_within_raw: assert property (@(posedge clock) disable iff (reset)
      RAW_W'(blk_ff) <= rawl_ff)
      else $error("block count exceeds remaining raw bytes");

   a_error_beat_form: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && oe_ff) |-> (ob_ff == 8'd0 && ol_ff))
      else $error("error beat must carry zero byte and last");

   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (ov_ff && ol_ff))
      else $error("queue pop without last beat loaded");

endmodule
